// ===== hw/rtl/lod_pkg.sv =====
// ----------------------------------------------------------------------------
// lod_pkg
// Shared widths, codes and control types of the offload decider.
// ----------------------------------------------------------------------------
package lod_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int FIELD_W = 32;
	localparam int LOAD_W  = 48;
	localparam int DBL_W   = 48;
	localparam int VBL_W   = 32;
	localparam int COST_W  = 64;

	// Digit-serial multiplier: wide operand times one digit of the other per cycle.
	localparam int MUL_A_W   = 48;
	localparam int MUL_B_W   = 48;
	localparam int MUL_DIG_W = 8;
	localparam int MUL_CNT_W = $clog2(MUL_B_W / MUL_DIG_W + 1);

	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 88;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_WEIGHT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIOLATION_DRAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_RATE    = 2'd2;

	typedef enum logic [2:0] {
		OP_LOAD_L = 3'd0,
		OP_LOAD_R = 3'd1,
		OP_EN_L   = 3'd2,
		OP_EN_R   = 3'd3,
		OP_COST_L = 3'd4,
		OP_COST_R = 3'd5
	} op_t;

	typedef struct packed {
		logic idle;
		logic mul_start;
		logic capture;
		logic commit;
		op_t  op;
	} ctl_t;

endpackage

// ===== hw/rtl/lod_mul.sv =====
// ----------------------------------------------------------------------------
// lod_mul
// Digit-serial unsigned multiplier, one digit of the second operand a cycle.
// ----------------------------------------------------------------------------
module lod_mul #(
	parameter int A_W   = 48,
	parameter int B_W   = 48,
	parameter int DIG_W = 8,
	localparam int CNT_W = $clog2(B_W / DIG_W + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	input  logic [CNT_W-1:0]   ndig,
	output logic               busy,
	output logic [A_W+B_W-1:0] p
);

	logic [A_W-1:0]       a_q;
	logic [A_W+B_W-1:0]   p_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [A_W+DIG_W-1:0] partial;

	// The upper half accumulates while the consumed digits of b shift out below.
	assign partial = (A_W+DIG_W)'(p_q[A_W+B_W-1:B_W]) + a_q * p_q[DIG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ndig;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{A_W{1'b0}}, b};
		end else if (cnt_q != '0) begin
			p_q <= {partial, p_q[B_W-1:DIG_W]};
		end
	end

	assign busy = (cnt_q != '0);
	assign p    = p_q;

endmodule

// ===== hw/rtl/lod_ctrl.sv =====
// ----------------------------------------------------------------------------
// lod_ctrl
// Sequencer that walks the six products of one request and commits the decision.
// ----------------------------------------------------------------------------
module lod_ctrl
	import lod_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_accept,
	input  logic mul_busy,
	input  logic slot_free,
	output ctl_t ctl
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ISSUE  = 4'b0010,
		ST_WAIT   = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

	state_t state_q;
	op_t    op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_LOAD_L;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_ISSUE;
						op_q    <= OP_LOAD_L;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!mul_busy) begin
						if (op_q == OP_COST_R) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_ISSUE;
							op_q    <= op_t'(op_q + 3'd1);
						end
					end
				end
				ST_DECIDE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl           = '0;
		ctl.op        = op_q;
		ctl.idle      = (state_q == ST_IDLE);
		ctl.mul_start = (state_q == ST_ISSUE);
		ctl.capture   = (state_q == ST_WAIT) && !mul_busy;
		ctl.commit    = (state_q == ST_DECIDE) && slot_free;
	end

endmodule

// ===== hw/rtl/lyapunov_offload_decider.sv =====
// ----------------------------------------------------------------------------
// lyapunov_offload_decider
// Drift-plus-penalty offload decision with delay and violation virtual queues.
// ----------------------------------------------------------------------------
// One request is worked on at a time; the block accepts the next one only
// after it has committed the decision on the last and returned to idle.
// The pace is set by the 48 x 8 bit digit-serial multiplier: four products
// of 32-bit operands run over four digits each, the two backlog products over
// six; each product passes through an issue and a wait state, and the
// request closes with the decision and the idle state that takes the next. A
// finished result waits in the output register while the next request is
// accepted and computed; the decision stalls only if that register is still
// full when the next result is ready.
module lyapunov_offload_decider
	import lod_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [FIELD_W-1:0]     cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// local_delay, remote_delay, local_energy, remote_energy
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// offload, delay_backlog_out, violation_backlog_out, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam logic [63:0] EW_WIDE = 64'd800 << FRAC_BITS;
	localparam logic [FIELD_W-1:0] EW_RST =
		(EW_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : EW_WIDE[31:0];
	localparam logic [63:0] DRAIN_WIDE = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam logic [FIELD_W-1:0] DRAIN_RST = DRAIN_WIDE[31:0];
	localparam logic [63:0] AR_WIDE = (FRAC_BITS >= 16) ?
		(64'd1395355 << ((FRAC_BITS - 16) & 31)) :
		(64'd1395355 >> ((16 - FRAC_BITS) & 31));
	localparam logic [FIELD_W-1:0] AR_RST =
		(AR_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : AR_WIDE[31:0];

	localparam logic [DBL_W-1:0] ONE_D = DBL_W'(1) << FRAC_BITS;
	localparam logic [VBL_W-1:0] ONE_V = VBL_W'(1) << FRAC_BITS;

	localparam logic [MUL_CNT_W-1:0] NARROW_DIG = MUL_CNT_W'(FIELD_W / MUL_DIG_W);
	localparam logic [MUL_CNT_W-1:0] FULL_DIG   = MUL_CNT_W'(MUL_B_W / MUL_DIG_W);
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	ctl_t ctl;
	logic in_accept;
	logic slot_free;

	logic [FIELD_W-1:0] ew_q, drain_q, ar_q;
	logic [DBL_W-1:0]   dbl_q;
	logic [VBL_W-1:0]   vbl_q;

	logic [FIELD_W-1:0] dl_q, dr_q, el_q, er_q;
	logic               viol_r_q;
	logic [LOAD_W-1:0]  load_l_q, load_r_q;
	logic [COST_W-1:0]  en_l_q, en_r_q, cost_l_q, cost_r_q;

	logic                 m_tvalid_q;
	logic                 out_off_q;
	logic [DBL_W-1:0]     out_dbl_q;
	logic [VBL_W-1:0]     out_vbl_q;

	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_CNT_W-1:0] mul_ndig;
	logic                 mul_busy;
	logic [PROD_W-1:0]    mul_p;

	logic [2*FIELD_W-1:0] prod_n, sh_n;
	logic [PROD_W-1:0]    sh_w;
	logic [LOAD_W-1:0]    load_sat;
	logic [COST_W-1:0]    en_val, term, en_sel, cost_val;
	logic [COST_W:0]      cost_sum;
	logic [FIELD_W+1:0]   d_ext, limit3;

	logic               off;
	logic [LOAD_W-1:0]  load_sel;
	logic               viol_sel;
	logic [DBL_W-1:0]   dbl_drained, dbl_next;
	logic [DBL_W:0]     dbl_sum;
	logic [VBL_W-1:0]   vbl_drained, vbl_next;
	logic [VBL_W:0]     vbl_sum;

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = ctl.idle;
	assign slot_free     = !m_tvalid_q || m_axis_tready;

	lod_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.mul_busy  (mul_busy),
		.slot_free (slot_free),
		.ctl       (ctl)
	);

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_ndig = NARROW_DIG;
		case (ctl.op)
			OP_LOAD_L: begin
				mul_a = MUL_A_W'(dl_q);
				mul_b = MUL_B_W'(ar_q);
			end
			OP_LOAD_R: begin
				mul_a = MUL_A_W'(dr_q);
				mul_b = MUL_B_W'(ar_q);
			end
			OP_EN_L: begin
				mul_a = MUL_A_W'(ew_q);
				mul_b = MUL_B_W'(el_q);
			end
			OP_EN_R: begin
				mul_a = MUL_A_W'(ew_q);
				mul_b = MUL_B_W'(er_q);
			end
			OP_COST_L: begin
				mul_a    = MUL_A_W'(load_l_q);
				mul_b    = MUL_B_W'(dbl_q);
				mul_ndig = FULL_DIG;
			end
			OP_COST_R: begin
				mul_a    = MUL_A_W'(load_r_q);
				mul_b    = MUL_B_W'(dbl_q);
				mul_ndig = FULL_DIG;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	lod_mul #(
		.A_W   (MUL_A_W),
		.B_W   (MUL_B_W),
		.DIG_W (MUL_DIG_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.ndig   (mul_ndig),
		.busy   (mul_busy),
		.p      (mul_p)
	);

	// A run over fewer digits leaves the product higher up in the register.
	assign prod_n   = mul_p[MUL_B_W+FIELD_W-1:MUL_B_W-FIELD_W];
	assign sh_n     = prod_n >> FRAC_BITS;
	assign load_sat = ((sh_n >> LOAD_W) != '0) ? '1 : sh_n[LOAD_W-1:0];

	// The violation backlog rides along with the remote energy term; all terms
	// are non-negative, so saturating the total once gives the same answer.
	assign en_val = sh_n + ((viol_r_q && ctl.op == OP_EN_R) ? COST_W'(vbl_q) : '0);

	assign sh_w     = mul_p >> FRAC_BITS;
	assign term     = ((sh_w >> COST_W) != '0) ? '1 : sh_w[COST_W-1:0];
	assign en_sel   = (ctl.op == OP_COST_R) ? en_r_q : en_l_q;
	assign cost_sum = {1'b0, term} + {1'b0, en_sel};
	assign cost_val = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

	// Remote delay is late when twice it exceeds three times the local delay.
	assign d_ext  = {2'b0, s_axis_tdata[2*FIELD_W-1:FIELD_W]} << 1;
	assign limit3 = ({2'b0, s_axis_tdata[FIELD_W-1:0]} << 1) +
		{2'b0, s_axis_tdata[FIELD_W-1:0]};

	always_ff @(posedge clk) begin
		if (in_accept) begin
			dl_q     <= s_axis_tdata[FIELD_W-1:0];
			dr_q     <= s_axis_tdata[2*FIELD_W-1:FIELD_W];
			el_q     <= s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
			er_q     <= s_axis_tdata[4*FIELD_W-1:3*FIELD_W];
			viol_r_q <= (d_ext > limit3);
		end
		if (ctl.capture) begin
			case (ctl.op)
				OP_LOAD_L: load_l_q <= load_sat;
				OP_LOAD_R: load_r_q <= load_sat;
				OP_EN_L:   en_l_q   <= en_val;
				OP_EN_R:   en_r_q   <= en_val;
				OP_COST_L: cost_l_q <= cost_val;
				OP_COST_R: cost_r_q <= cost_val;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ew_q    <= EW_RST;
			drain_q <= DRAIN_RST;
			ar_q    <= AR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENERGY_WEIGHT:   ew_q    <= cfg_data;
				REG_VIOLATION_DRAIN: drain_q <= cfg_data;
				REG_ARRIVAL_RATE:    ar_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Ties stay local.
	assign off      = (cost_r_q < cost_l_q);
	assign load_sel = off ? load_r_q : load_l_q;
	assign viol_sel = off && viol_r_q;

	assign dbl_drained = (dbl_q > ONE_D) ? (dbl_q - ONE_D) : '0;
	assign dbl_sum     = {1'b0, dbl_drained} + {1'b0, load_sel};
	assign dbl_next    = dbl_sum[DBL_W] ? '1 : dbl_sum[DBL_W-1:0];

	assign vbl_drained = (vbl_q > drain_q) ? (vbl_q - drain_q) : '0;
	assign vbl_sum     = {1'b0, vbl_drained} + (viol_sel ? {1'b0, ONE_V} : '0);
	assign vbl_next    = vbl_sum[VBL_W] ? '1 : vbl_sum[VBL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbl_q      <= '0;
			vbl_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else if (ctl.commit) begin
			dbl_q      <= dbl_next;
			vbl_q      <= vbl_next;
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_off_q <= off;
			out_dbl_q <= dbl_next;
			out_vbl_q <= vbl_next;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {
		(OUT_TDATA_W - 1 - DBL_W - VBL_W)'(0), out_vbl_q, out_dbl_q, out_off_q
	};

endmodule

// ===== hw/rtl/lod_chk.sv =====
// ----------------------------------------------------------------------------
// lod_chk
// Port-level checks of the offload decider, bound to the top level.
// ----------------------------------------------------------------------------
module lod_chk
	import lod_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A result that is not taken stays as it is.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	// Only one request is in work at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input still ready right after a request was taken");

	// The block becomes busy only by taking a request.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid))
		else $error("input ready dropped without a request");

	// A new result comes only out of work on a request.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared while the block was idle");

	// The zero fill above the result fields stays clear.
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:1+DBL_W+VBL_W] == '0))
		else $error("fill bits of the result are not zero");

endmodule

bind lyapunov_offload_decider lod_chk u_lod_chk (.*);

// ===== verif/tb_lyapunov_offload_decider.sv =====
// ----------------------------------------------------------------------------
// tb_lyapunov_offload_decider
// Self-checking bench for the drift-plus-penalty offload decider. A local
// model of both virtual queues predicts each decision at the moment a request
// is accepted. A checker compares every result, field by field, in order.
// Directed cases come first, then register extremes, back-to-back and
// hold-off traffic, random phases under varied settings, and saturated
// backlogs.
// ----------------------------------------------------------------------------
module tb_lyapunov_offload_decider;
	import lod_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [63:0] ONE_FX = 64'd1 << FRAC;
	localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

	// Register values after reset at the default fraction width.
	localparam logic [FIELD_W-1:0] WEIGHT_RESET = 32'd52428800;
	localparam logic [FIELD_W-1:0] DRAIN_RESET  = 32'd6554;
	localparam logic [FIELD_W-1:0] RATE_RESET   = 32'd1395355;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	localparam int DBL_LSB  = 1;
	localparam int VBL_LSB  = DBL_LSB + DBL_W;
	localparam int FILL_LSB = VBL_LSB + VBL_W;

	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 64;
	localparam int LIMIT_CYCLES = 600000;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 220;

	// Packed so that the last field, local_delay, lands in the lowest bits of tdata.
	typedef struct packed {
		logic [FIELD_W-1:0] remote_energy;
		logic [FIELD_W-1:0] local_energy;
		logic [FIELD_W-1:0] remote_delay;
		logic [FIELD_W-1:0] local_delay;
	} offload_req_t;

	typedef struct {
		logic             offload;
		logic [DBL_W-1:0] delay_bl;
		logic [VBL_W-1:0] viol_bl;
	} decision_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [FIELD_W-1:0]     cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Model of the block's registers and virtual queues.
	logic [FIELD_W-1:0] weight_reg = WEIGHT_RESET;
	logic [FIELD_W-1:0] drain_reg  = DRAIN_RESET;
	logic [FIELD_W-1:0] rate_reg   = RATE_RESET;
	logic [DBL_W-1:0]   model_delay_bl = '0;
	logic [VBL_W-1:0]   model_viol_bl  = '0;

	decision_t pending_decisions[$];

	int  mismatches = 0;
	int  requests_sent = 0;
	int  results_seen = 0;
	int  offloads = 0;
	int  config_settings = 1;
	int  cycles = 0;
	int  stall_requests = 0;
	int  stalls_served = 0;
	int  hold_left = 0;
	bit  quiet = 1'b0;

	lyapunov_offload_decider i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles,
				pending_decisions.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Fixed-point arithmetic of the decision
	// ------------------------------------------------------------------------
	function automatic logic [63:0] mul_frac_sat(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = ({64'd0, a} * {64'd0, b}) >> FRAC;
		return (prod[127:64] != '0) ? '1 : prod[63:0];
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[64] ? '1 : sum[63:0];
	endfunction

	function automatic logic [63:0] load_of_delay(logic [FIELD_W-1:0] delay);
		logic [63:0] l;
		l = mul_frac_sat({32'd0, delay}, {32'd0, rate_reg});
		return (l > MAX48) ? MAX48 : l;
	endfunction

	function automatic logic [63:0] option_cost(logic [63:0] load, logic viol,
			logic [FIELD_W-1:0] energy);
		logic [63:0] c;
		c = mul_frac_sat(load, {16'd0, model_delay_bl});
		if (viol)
			c = add_sat(c, {32'd0, model_viol_bl});
		return add_sat(c, mul_frac_sat({32'd0, weight_reg}, {32'd0, energy}));
	endfunction

	// Works out the decision for one accepted request and advances both queues.
	function automatic void predict_decision(offload_req_t req);
		logic [33:0] deadline3;
		logic        viol_l, viol_r, off, viol_c;
		logic [63:0] load_l, load_r, cost_l, cost_r, load_c;
		logic [64:0] dsum;
		logic [32:0] vsum;
		decision_t   d;
		deadline3 = 34'(req.local_delay) * 34'd3;
		viol_l = (34'(req.local_delay) * 34'd2) > deadline3;
		viol_r = (34'(req.remote_delay) * 34'd2) > deadline3;
		load_l = load_of_delay(req.local_delay);
		load_r = load_of_delay(req.remote_delay);
		cost_l = option_cost(load_l, viol_l, req.local_energy);
		cost_r = option_cost(load_r, viol_r, req.remote_energy);
		// Ties, saturated ones included, keep the task local.
		off = cost_r < cost_l;
		load_c = off ? load_r : load_l;
		viol_c = off ? viol_r : viol_l;
		dsum = {17'd0, (64'(model_delay_bl) > ONE_FX) ? 48'(64'(model_delay_bl) - ONE_FX)
			: 48'd0} + {1'b0, load_c};
		model_delay_bl = (dsum > {1'b0, MAX48}) ? MAX48[DBL_W-1:0] : dsum[DBL_W-1:0];
		vsum = {1'b0, (model_viol_bl > drain_reg) ? model_viol_bl - drain_reg : 32'd0};
		if (viol_c)
			vsum = vsum + 33'(ONE_FX);
		model_viol_bl = vsum[32] ? '1 : vsum[VBL_W-1:0];
		d.offload = off;
		d.delay_bl = model_delay_bl;
		d.viol_bl = model_viol_bl;
		pending_decisions.push_back(d);
	endfunction

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left == 0 && stall_requests != stalls_served) begin
			stalls_served = stall_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (quiet) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 13);
		end
	end

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch in %s of result %0d: got %h, expected %h", what, results_seen,
			got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		decision_t              want;
		logic [OUT_TDATA_W-1:0] got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			results_seen++;
			if (got[0])
				offloads++;
			if (pending_decisions.size() == 0) begin
				report_mismatch("unexpected result", got[DBL_LSB +: DBL_W], 0);
			end else begin
				want = pending_decisions.pop_front();
				if (got[0] !== want.offload)
					report_mismatch("offload", got[0], want.offload);
				if (got[DBL_LSB +: DBL_W] !== want.delay_bl)
					report_mismatch("delay_backlog_out", got[DBL_LSB +: DBL_W], want.delay_bl);
				if (got[VBL_LSB +: VBL_W] !== want.viol_bl)
					report_mismatch("violation_backlog_out", got[VBL_LSB +: VBL_W],
						want.viol_bl);
				if (got[OUT_TDATA_W-1:FILL_LSB] !== '0)
					report_mismatch("zero fill", got[OUT_TDATA_W-1:FILL_LSB], 0);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side and configuration
	// ------------------------------------------------------------------------
	task automatic send_request(logic [FIELD_W-1:0] ld, logic [FIELD_W-1:0] rd,
			logic [FIELD_W-1:0] le, logic [FIELD_W-1:0] re);
		offload_req_t req;
		req.local_delay = ld;
		req.remote_delay = rd;
		req.local_energy = le;
		req.remote_energy = re;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_decision(req);
		requests_sent++;
		while (!quiet && $urandom_range(99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [FIELD_W-1:0] pick_value(int unsigned small_max);
		case ($urandom_range(19))
			0, 1: return '0;
			2: return '1;
			3, 4: return $urandom;
			default: return $urandom_range(small_max, 0);
		endcase
	endfunction

	task automatic send_random_request();
		logic [FIELD_W-1:0] ld, rd;
		logic [33:0]        bound;
		ld = pick_value(32'h0000_4000);
		if ($urandom_range(3) == 0) begin
			// Straddle the deadline of one and a half times the local delay.
			bound = ((34'(ld) * 34'd3) >> 1) + 34'($urandom_range(2)) - 34'd1;
			rd = (bound > 34'hFFFF_FFFF) ? '1 : bound[FIELD_W-1:0];
		end else begin
			rd = pick_value(32'h0000_4000);
		end
		send_request(ld, rd, pick_value(32'h0010_0000), pick_value(32'h0010_0000));
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_ENERGY_WEIGHT:   weight_reg = value;
			REG_VIOLATION_DRAIN: drain_reg = value;
			REG_ARRIVAL_RATE:    rate_reg = value;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [FIELD_W-1:0] weight, logic [FIELD_W-1:0] drain,
			logic [FIELD_W-1:0] rate);
		wait_results_drained();
		write_reg(REG_ENERGY_WEIGHT, weight);
		write_reg(REG_VIOLATION_DRAIN, drain);
		write_reg(REG_ARRIVAL_RATE, rate);
		cfg_we <= 1'b0;
		config_settings++;
	endtask

	function automatic logic [FIELD_W-1:0] pick_reg(logic [FIELD_W-1:0] reset_val,
			int unsigned small_max);
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return reset_val;
			3: return $urandom_range(small_max, 0);
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed_cases();
		// Both queues start empty, so the floors at zero are hit here.
		send_request(32'h0, 32'h0, 32'h0, 32'h0);
		send_request(32'h1000, 32'h1000, 32'h0001_0000, 32'h0001_0000);
		send_request(32'h1000, 32'h1000, 32'h0002_0000, 32'h0001_0000);
		// Remote delay exactly at the deadline, then one step over it.
		send_request(32'h2000, 32'h3000, 32'h0004_0000, 32'h0001_0000);
		send_request(32'h2000, 32'h3001, 32'h0004_0000, 32'h0000_0000);
		repeat (3)
			send_request(32'h2000, 32'h8000, 32'h0010_0000, 32'h0);
		send_request(32'h0, 32'h1, 32'h1, 32'h0);
		send_request(32'h100, 32'h100, 32'hFFFF_FFFF, 32'h0);
		send_request(32'h100, 32'h100, 32'h0, 32'hFFFF_FFFF);
		send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
		send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_request(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
	endtask

	task automatic test_register_extremes();
		set_config('0, '0, '0);
		repeat (2)
			send_random_request();
		set_config('1, '1, '1);
		repeat (2)
			send_random_request();
		set_config('0, '1, RATE_RESET);
		repeat (2)
			send_random_request();
		set_config('1, '0, 32'h0000_0100);
		repeat (2)
			send_random_request();
		// A write to an index with no register behind it must change nothing.
		wait_results_drained();
		write_reg(REG_UNMAPPED, $urandom);
		cfg_we <= 1'b0;
		repeat (2)
			send_random_request();
		set_config(WEIGHT_RESET, DRAIN_RESET, RATE_RESET);
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		repeat (150)
			send_random_request();
		quiet = 1'b0;
	endtask

	task automatic test_output_pressure();
		stall_requests++;
		repeat (14)
			send_random_request();
		wait_results_drained();
		repeat (4)
			send_random_request();
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < PHASES; p++) begin
			set_config(pick_reg(WEIGHT_RESET, 32'h0100_0000), pick_reg(DRAIN_RESET, 32'h0004_0000),
				pick_reg(RATE_RESET, 32'h0040_0000));
			repeat (PHASE_ITEMS)
				send_random_request();
		end
	endtask

	task automatic test_backlog_saturation();
		set_config('1, DRAIN_RESET, '1);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
		// With the delay backlog pinned, both costs saturate and the task stays local.
		send_request(32'h0010_0000, 32'h0010_0000, 32'hFFFF_FFFF, 32'h0);
		send_request(32'h0010_0000, 32'h0020_0000, 32'hFFFF_FFFF, 32'h0);
		send_request(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
		send_request(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_register_extremes();
		test_back_to_back();
		test_output_pressure();
		test_random_phases();
		test_backlog_saturation();
		wait_results_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		$display("%0d requests over %0d register settings, %0d results, %0d offloaded",
			requests_sent, config_settings, results_seen, offloads);
		$display("covered back-to-back traffic, a %0d-cycle output hold-off and saturated backlogs",
			HOLD_CYCLES);
		if (mismatches == 0 && pending_decisions.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== lyapunov_offload_decider.f =====
hw/rtl/lod_pkg.sv
hw/rtl/lod_mul.sv
hw/rtl/lod_ctrl.sv
hw/rtl/lyapunov_offload_decider.sv
hw/rtl/lod_chk.sv
verif/tb_lyapunov_offload_decider.sv
